FILE: design/gf16_erasure_parity_encode_assert.svh
// Assertion macros for the checker file.
// Each expects clk and rst_n in the scope where it is used.
`ifndef GF16_ERASURE_PARITY_ENCODE_ASSERT_SVH
`define GF16_ERASURE_PARITY_ENCODE_ASSERT_SVH

// same-cycle implication
`define GF16EP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GF16EP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gf16ep_pkg.sv
package gf16ep_pkg;

    localparam int PLANE_WIDTH_DEF    = 64;
    localparam int MAX_DATA_DISKS_DEF = 16;

    // field polynomial x^4 + x + 1
    localparam logic [4:0] GF_POLY = 5'h13;

    localparam int NUM_PLANES = 4;
    localparam int DISK_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int COEF_W     = 4;
    localparam int ROW_W      = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] DISK_COUNT_RST = 5'd1;

endpackage

FILE: design/gf16ep_mul.sv
// Bitsliced GF(16) multiply: every symbol of the four planes times coef.
module gf16ep_mul #(
    parameter int PLANE_WIDTH = gf16ep_pkg::PLANE_WIDTH_DEF
) (
    input  logic [gf16ep_pkg::NUM_PLANES-1:0][PLANE_WIDTH-1:0] planes,
    input  logic [gf16ep_pkg::COEF_W-1:0]                      coef,
    output logic [gf16ep_pkg::NUM_PLANES-1:0][PLANE_WIDTH-1:0] prod
);
    import gf16ep_pkg::*;

    always_comb
    begin
        logic [NUM_PLANES-1:0][PLANE_WIDTH-1:0] term;
        logic [NUM_PLANES-1:0][PLANE_WIDTH-1:0] shifted;
        logic [PLANE_WIDTH-1:0]                 top;

        term = planes;
        prod = '0;
        for (int b = 0; b < COEF_W; b++)
        begin
            if (coef[b])
                prod = prod ^ term;
            // times x: move planes up, fold the top plane back through the polynomial
            top = term[NUM_PLANES-1];
            shifted[0] = GF_POLY[0] ? top : '0;
            for (int j = 1; j < NUM_PLANES; j++)
                shifted[j] = term[j-1] ^ (GF_POLY[j] ? top : '0);
            term = shifted;
        end
    end

endmodule

FILE: design/gf16_erasure_parity_encode.sv
// Channel  | Dir | Beat contents
// s_axis   | in  | tuser: disk_index; tdata: plane_zero..plane_three (lowest first)
// m_axis   | out | tdata: parity_zero..parity_three (lowest first)
// cfg      | in  | index 0 coef_row, index 1 data_disk_count; write when cfg_we
//
// One beat per cycle sustained while no parity beat is held on m_axis. From input beat to parity beat:
// input register, then GF multiply and accumulator XOR into the output register.
// rst_n is asynchronous: clears the accumulator, coef_row = 0, data_disk_count = 1.
// A parity beat held on m_axis stalls only a pending last-disk beat and the input behind it;
// other beats keep flowing. s_axis_tready depends combinationally on m_axis_tready.
module gf16_erasure_parity_encode #(
    parameter int PLANE_WIDTH    = gf16ep_pkg::PLANE_WIDTH_DEF,
    parameter int MAX_DATA_DISKS = gf16ep_pkg::MAX_DATA_DISKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] disk_index
    input  logic [gf16ep_pkg::DISK_W-1:0]       s_axis_tuser,
    // plane_zero, plane_one, plane_two, plane_three, PLANE_WIDTH bits each, zero pad
    input  logic [((4*PLANE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // parity_zero, parity_one, parity_two, parity_three, PLANE_WIDTH bits each, zero pad
    output logic [((4*PLANE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,

    input  logic                                cfg_we,
    input  logic [gf16ep_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gf16ep_pkg::ROW_W-1:0]        cfg_data
);
    import gf16ep_pkg::*;

    localparam int PLANES_W = NUM_PLANES * PLANE_WIDTH;
    localparam int TDATA_W  = ((PLANES_W + 7) / 8) * 8;

    typedef logic [NUM_PLANES-1:0][PLANE_WIDTH-1:0] planes_t;

    // configuration
    logic [ROW_W-1:0]   coef_row_reg;
    logic [COUNT_W-1:0] disk_count_reg;

    // input stage
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [DISK_W-1:0]  s1_disk_reg;
    planes_t            s1_planes_reg;

    // accumulator and output stage
    planes_t            acc_reg;
    planes_t            acc_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    planes_t            m_planes_reg;

    logic [COUNT_W-1:0] count_eff;
    logic               s1_use;
    logic               s1_last;
    logic               s1_drain;
    logic               s_accept;
    logic [COEF_W-1:0]  coef;
    planes_t            prod;

    // counts above the disk limit act as the limit; zero ignores every beat
    assign count_eff = (disk_count_reg > COUNT_W'(MAX_DATA_DISKS)) ?
                       COUNT_W'(MAX_DATA_DISKS) : disk_count_reg;

    assign s1_use   = s1_valid_reg && ({1'b0, s1_disk_reg} < count_eff);
    assign s1_last  = s1_use && (({1'b0, s1_disk_reg} + COUNT_W'(1)) == count_eff);
    // only a last-disk beat waits for room in the output register
    assign s1_drain = !s1_last || !m_valid_reg || m_axis_tready;

    assign s_axis_tready = !s1_valid_reg || s1_drain;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign coef = coef_row_reg[s1_disk_reg*COEF_W +: COEF_W];

    gf16ep_mul #(
        .PLANE_WIDTH (PLANE_WIDTH)
    ) u_mul (
        .planes (s1_planes_reg),
        .coef   (coef),
        .prod   (prod)
    );

    always_comb
    begin
        acc_next = acc_reg;
        if (s1_use && s1_drain)
        begin
            if (s1_disk_reg == '0)
                acc_next = prod;
            else
                acc_next = acc_reg ^ prod;
        end
    end

    assign s1_valid_next = s_accept || (s1_valid_reg && !s1_drain);

    always_comb
    begin
        priority if (s1_last && s1_drain)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_row_reg   <= '0;
            disk_count_reg <= DISK_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_ROW:   coef_row_reg   <= cfg_data;
                CFG_DISK_COUNT: disk_count_reg <= cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            acc_reg      <= acc_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_disk_reg   <= s_axis_tuser;
            s1_planes_reg <= s_axis_tdata[PLANES_W-1:0];
        end
        if (s1_last && s1_drain)
            m_planes_reg <= acc_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDATA_W'(m_planes_reg);

endmodule

FILE: design/gf16ep_checker.sv
`include "gf16_erasure_parity_encode_assert.svh"

module gf16ep_checker #(
    parameter int DATA_W = 256
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);

    `GF16EP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "parity beat dropped while stalled")
    `GF16EP_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "parity data changed while stalled")
    // input backpressure only comes from a stalled parity beat
    `GF16EP_ASSERT_NOW(a_ready_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")
    // a fresh parity beat traces back through the input register to an accepted input beat
    `GF16EP_ASSERT_NOW(a_out_origin, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "parity beat without input beat")

endmodule

bind gf16_erasure_parity_encode gf16ep_checker #(
    .DATA_W (TDATA_W)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
